// ===== src/dsta_pkg.sv =====
// shared types and constants for the defect-skipping tile allocator
`default_nettype none

package dsta_pkg;

  localparam int MAX_TILES = 1024;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 10;
  localparam int ID_W      = 10;

  localparam logic [CFG_IDX_W-1:0] REG_CARD_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_TOTAL = 3'd4;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_INVALID = 3'd2,
    ST_LARGE   = 3'd3,
    ST_NO_GOOD = 3'd4,
    ST_DONE    = 3'd5
  } status_t;

  typedef struct packed {
    logic    clear_step;
    logic    load_item;
    logic    write_mark;
    logic    advance;
    logic    place_ok;
    logic    emit;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic topo_ready;
    logic topo_invalid;
    logic topo_large;
    logic op_place;
    logic id_range_err;
    logic ranks_done;
    logic scan_exhausted;
    logic tile_bad;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/dsta_dp.sv =====
// datapath: config registers, tile count pipeline, bad-tile memory, scan counters, result register
`default_nettype none

module dsta_dp #(
  parameter int MAX_TILES = dsta_pkg::MAX_TILES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [dsta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dsta_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_operation,
  input  wire logic [dsta_pkg::ID_W-1:0]      in_bad_tile,
  input  wire dsta_pkg::dp_cmd_t              cmd,
  output dsta_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output dsta_pkg::status_t                   out_status,
  output logic [dsta_pkg::COORD_W-1:0]        out_rank,
  output logic [dsta_pkg::COORD_W-1:0]        out_card_row,
  output logic [dsta_pkg::COORD_W-1:0]        out_card_col,
  output logic [dsta_pkg::COORD_W-1:0]        out_tile_row,
  output logic [dsta_pkg::COORD_W-1:0]        out_tile_col,
  output logic                                out_final
);

  localparam int CFG_W  = dsta_pkg::CFG_W;
  localparam int ID_W   = dsta_pkg::ID_W;
  localparam int ADDR_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_W  = $clog2(MAX_TILES + 2);
  localparam int PROD_W = CNT_W + CFG_W;
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_TILES);
  localparam logic [CNT_W-1:0]  CNT_SAT  = CNT_W'(MAX_TILES + 1);
  localparam logic [PROD_W-1:0] PROD_MAX = PROD_W'(MAX_TILES);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_TILES - 1);

  // saturating product, anything beyond the tile limit reads as limit plus one
  function automatic logic [CNT_W-1:0] sat_mul(input logic [CNT_W-1:0] a,
                                               input logic [CFG_W-1:0] b);
    logic [PROD_W-1:0] p;
    p = {{CFG_W{1'b0}}, a} * {{CNT_W{1'b0}}, b};
    return (p > PROD_MAX) ? CNT_SAT : p[CNT_W-1:0];
  endfunction

  logic [CFG_W-1:0] card_rows, card_cols, tile_rows, tile_cols, rank_total;
  logic [1:0]       settle;
  logic             cfg_hit;

  logic [CNT_W-1:0] row_sat, prod1, prod2, tile_count;

  logic             op_q;
  logic [ID_W-1:0]  id_q;

  logic             mem [MAX_TILES];
  logic             rdata;
  logic [ADDR_W-1:0] clear_addr;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic             mem_wdata;

  logic [CNT_W-1:0] scan_id;
  logic [CFG_W-1:0] scan_card_row, scan_card_col, scan_tile_row, scan_tile_col;
  logic [CFG_W-1:0] ranks_placed;
  logic [CFG_W-1:0] tc_inc, tr_inc, cc_inc, ranks_inc;

  logic [CNT_W+ID_W-1:0] id_ext, count_ext;

  assign cfg_hit = cfg_we && (cfg_index <= dsta_pkg::REG_RANK_TOTAL);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      card_rows  <= CFG_W'(1);
      card_cols  <= CFG_W'(1);
      tile_rows  <= CFG_W'(1);
      tile_cols  <= CFG_W'(1);
      rank_total <= CFG_W'(1);
      settle     <= 2'd3;
    end else begin
      if (cfg_hit) begin
        settle <= 2'd3;
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
      if (cfg_we) begin
        case (cfg_index)
          dsta_pkg::REG_CARD_ROWS:  card_rows  <= cfg_data;
          dsta_pkg::REG_CARD_COLS:  card_cols  <= cfg_data;
          dsta_pkg::REG_TILE_ROWS:  tile_rows  <= cfg_data;
          dsta_pkg::REG_TILE_COLS:  tile_cols  <= cfg_data;
          dsta_pkg::REG_RANK_TOTAL: rank_total <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // tile count, one multiply per stage
  assign row_sat = (PROD_W'(card_rows) > PROD_MAX) ? CNT_SAT : CNT_W'(card_rows);

  always_ff @(posedge clk) begin
    prod1      <= sat_mul(row_sat, card_cols);
    prod2      <= sat_mul(prod1, tile_rows);
    tile_count <= sat_mul(prod2, tile_cols);
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q <= in_operation;
      id_q <= in_bad_tile;
    end
  end

  // bad-tile memory
  always_comb begin
    mem_we    = cmd.clear_step || cmd.write_mark;
    mem_waddr = cmd.clear_step ? clear_addr : ADDR_W'(id_q);
    mem_wdata = !cmd.clear_step;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[scan_id[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + ADDR_W'(1);
    end
  end

  // scan position
  assign tc_inc    = scan_tile_col + CFG_W'(1);
  assign tr_inc    = scan_tile_row + CFG_W'(1);
  assign cc_inc    = scan_card_col + CFG_W'(1);
  assign ranks_inc = ranks_placed + CFG_W'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      scan_id       <= '0;
      scan_card_row <= '0;
      scan_card_col <= '0;
      scan_tile_row <= '0;
      scan_tile_col <= '0;
      ranks_placed  <= '0;
    end else begin
      if (cmd.advance) begin
        scan_id <= scan_id + CNT_W'(1);
        if (tc_inc >= tile_cols) begin
          scan_tile_col <= '0;
          if (tr_inc >= tile_rows) begin
            scan_tile_row <= '0;
            if (cc_inc >= card_cols) begin
              scan_card_col <= '0;
              scan_card_row <= scan_card_row + CFG_W'(1);
            end else begin
              scan_card_col <= cc_inc;
            end
          end else begin
            scan_tile_row <= tr_inc;
          end
        end else begin
          scan_tile_col <= tc_inc;
        end
      end
      if (cmd.place_ok) begin
        ranks_placed <= ranks_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.code;
      if (cmd.place_ok) begin
        out_rank     <= ranks_placed[dsta_pkg::COORD_W-1:0];
        out_card_row <= scan_card_row[dsta_pkg::COORD_W-1:0];
        out_card_col <= scan_card_col[dsta_pkg::COORD_W-1:0];
        out_tile_row <= scan_tile_row[dsta_pkg::COORD_W-1:0];
        out_tile_col <= scan_tile_col[dsta_pkg::COORD_W-1:0];
        out_final    <= (ranks_inc == rank_total);
      end else begin
        out_rank     <= '0;
        out_card_row <= '0;
        out_card_col <= '0;
        out_tile_row <= '0;
        out_tile_col <= '0;
        out_final    <= 1'b0;
      end
    end
  end

  // status towards the controller
  assign id_ext    = {{CNT_W{1'b0}}, id_q};
  assign count_ext = {{ID_W{1'b0}}, tile_count};

  always_comb begin
    stat.clear_done     = (clear_addr == ADDR_LAST);
    stat.topo_ready     = (settle == 2'd0);
    stat.topo_invalid   = (card_rows == '0) || (card_cols == '0) || (tile_rows == '0) ||
                          (tile_cols == '0) || (rank_total == '0);
    stat.topo_large     = (tile_count > CNT_MAX);
    stat.op_place       = op_q;
    stat.id_range_err   = (id_ext >= count_ext);
    stat.ranks_done     = (ranks_placed >= rank_total);
    stat.scan_exhausted = (scan_id >= tile_count);
    stat.tile_bad       = rdata;
    stat.out_free       = !out_valid || out_ready;
  end

  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.write_mark |-> (id_ext < count_ext) && !stat.topo_large)
    else $error("mark written outside the tile count");

  a_place_good_tile: assert property (@(posedge clk) disable iff (rst)
    cmd.place_ok |-> !rdata && (scan_id < tile_count) && (ranks_placed < rank_total))
    else $error("placement on a bad or exhausted tile");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("result overwritten before it was taken");

  a_no_cfg_restart_mid_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.place_ok |=> !$past(cfg_hit))
    else $error("scan restarted during a placement");

endmodule

`default_nettype wire

// ===== src/dsta_ctrl.sv =====
// controller state machine for the tile allocator
`default_nettype none

module dsta_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dsta_pkg::dp_stat_t stat,
  output dsta_pkg::dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_FETCH,
    S_CHECK
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && stat.topo_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = dsta_pkg::ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.topo_invalid && !stat.topo_large && stat.op_place && !stat.ranks_done) begin
          state_next = S_FETCH;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
          if (stat.topo_invalid) begin
            cmd.code = dsta_pkg::ST_INVALID;
          end else if (stat.topo_large) begin
            cmd.code = dsta_pkg::ST_LARGE;
          end else if (stat.op_place) begin
            cmd.code = dsta_pkg::ST_DONE;
          end else if (stat.id_range_err) begin
            cmd.code = dsta_pkg::ST_RANGE;
          end else begin
            cmd.write_mark = 1'b1;
          end
        end
      end
      S_FETCH: begin
        if (!stat.scan_exhausted) begin
          state_next = S_CHECK;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.code   = dsta_pkg::ST_NO_GOOD;
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (stat.tile_bad) begin
          cmd.advance = 1'b1;
          state_next  = S_FETCH;
        end else if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.place_ok = 1'b1;
          cmd.advance  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/defect_skipping_tile_allocator.sv =====
// top level: assigns logical ranks to good tiles, skipping tiles marked bad
// a mark beat's result is registered in S_DECIDE when the output is free; one beat at a time
// a place beat scans via S_FETCH and S_CHECK, skipping bad tiles by the registered bitmap read
// topology and range errors return from S_DECIDE; the tile count settles after a config write
// after reset the bitmap is cleared one entry per cycle over all MAX_TILES, with no beat taken
// reset restores all config registers to 1, clears the bitmap and restarts placement
`default_nettype none

module defect_skipping_tile_allocator #(
  parameter int MAX_TILES = dsta_pkg::MAX_TILES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [dsta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dsta_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [15:0]                    s_tdata,  // bad_tile[9:0], zero pad
  input  wire logic                           s_tuser,  // operation
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // rank, card_row, card_col, tile_row, tile_col (10 bits each), zero pad
  output logic [55:0]                         m_tdata,
  output logic [2:0]                          m_tuser,  // status
  output logic                                m_tlast   // final_rank
);

  dsta_pkg::dp_cmd_t  cmd;
  dsta_pkg::dp_stat_t stat;
  dsta_pkg::status_t  out_status;
  logic [dsta_pkg::COORD_W-1:0] out_rank, out_card_row, out_card_col;
  logic [dsta_pkg::COORD_W-1:0] out_tile_row, out_tile_col;

  dsta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dsta_dp #(
    .MAX_TILES (MAX_TILES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_operation (s_tuser),
    .in_bad_tile  (s_tdata[dsta_pkg::ID_W-1:0]),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (out_status),
    .out_rank     (out_rank),
    .out_card_row (out_card_row),
    .out_card_col (out_card_col),
    .out_tile_row (out_tile_row),
    .out_tile_col (out_tile_col),
    .out_final    (m_tlast)
  );

  assign m_tuser = out_status;
  assign m_tdata = {6'b0, out_tile_col, out_tile_row, out_card_col, out_card_row, out_rank};

endmodule

`default_nettype wire
